// ===== design/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and constants shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef enum logic [1:0] {
    ST_RUN      = 2'd0,
    ST_DONE     = 2'd1,
    ST_NO_CRLF  = 2'd2,
    ST_BAD_ZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_CR   = 2'd2,
    PH_LF   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SH_EMPTY = 2'd0,
    SH_ZERO  = 2'd1,
    SH_OTHER = 2'd2
  } shape_t;

  typedef enum logic {
    CFG_CHUNKED_MODE   = 1'b0,
    CFG_CONTENT_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    cfg_index_t  index;
    logic [31:0] value;
  } cfg_item_t;

  // Classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_cr;
    logic       is_lf;
    logic       is_zero;
    logic       is_hex;
    logic [3:0] hex;
  } cls_t;

endpackage

// ===== design/hcbd_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface hcbd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/hcbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw bytes and classifies them (CR, LF, '0', hex digit value).
// ----------------------------------------------------------------------------
module hcbd_front
  import hcbd_pkg::*;
(
  hcbd_chan_if.sink stream,
  input  logic      push_ready,
  output logic      push_valid,
  output cls_t      push_item
);

  logic [7:0] c;

  assign c            = stream.payload.data_byte;
  assign stream.ready = push_ready;
  assign push_valid   = stream.valid;

  always_comb begin
    push_item           = '0;
    push_item.data_byte = c;
    push_item.is_cr     = (c == CHAR_CR);
    push_item.is_lf     = (c == CHAR_LF);
    push_item.is_zero   = (c == CHAR_ZERO);
    if (c >= 8'h30 && c <= 8'h39) begin
      push_item.is_hex = 1'b1;
      push_item.hex    = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      push_item.is_hex = 1'b1;
      push_item.hex    = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      push_item.is_hex = 1'b1;
      push_item.hex    = 4'(c - 8'h37);
    end
  end

endmodule

// ===== design/hcbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module hcbd_queue
  import hcbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cls_t push_item,
  output logic push_ready,
  output logic pop_valid,
  output cls_t pop_item,
  input  logic pop_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/hcbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_back
// Decoding state machine: length counting, size lines, chunk data and the
// trailing CR LF, with a registered result stage.
// ----------------------------------------------------------------------------
module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        chunked_mode,
  input  logic [31:0] content_length,
  input  logic        pop_valid,
  input  cls_t        pop_item,
  output logic        pop_ready,
  hcbd_chan_if.source result
);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] accum;
    logic                   stopped;
    shape_t                 shape;
  } line_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic line_t line_char(line_t ln, logic is_zero, logic is_hex,
                                      logic [3:0] hex);
    line_t r;
    r = ln;
    r.shape = (ln.shape == SH_EMPTY && is_zero) ? SH_ZERO : SH_OTHER;
    if (ln.stopped || !is_hex) begin
      r.stopped = 1'b1;
    end else if (ln.accum[COUNT_WIDTH-1 -: 4] != 4'd0) begin
      r.accum = COUNT_MAX;
    end else begin
      r.accum = {ln.accum[COUNT_WIDTH-5:0], hex};
    end
    return r;
  endfunction

  phase_t                 phase, phase_next;
  logic [COUNT_WIDTH-1:0] chunk_remaining, chunk_remaining_next;
  line_t                  line, line_next;
  logic                   pending_cr, pending_cr_next;
  logic [COUNT_WIDTH-1:0] bytes_taken, bytes_taken_next;
  status_t                final_status, final_status_next;

  logic                   res_valid;
  out_item_t              res_item;
  logic                   pop;
  logic                   body_valid;
  logic [COUNT_WIDTH-1:0] limit;
  logic [COUNT_WIDTH-1:0] taken_inc;
  logic [COUNT_WIDTH-1:0] remaining_dec;
  line_t                  line_cr;

  assign pop_ready      = !res_valid || result.ready;
  assign pop            = pop_valid && pop_ready;
  assign result.valid   = res_valid;
  assign result.payload = res_item;
  assign limit          = COUNT_WIDTH'(content_length);
  assign taken_inc      = bytes_taken + 1'b1;
  assign remaining_dec  = chunk_remaining - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      line            <= '{accum: '0, stopped: 1'b0, shape: SH_EMPTY};
      pending_cr      <= 1'b0;
      bytes_taken     <= '0;
      final_status    <= ST_RUN;
      res_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      line            <= line_next;
      pending_cr      <= pending_cr_next;
      bytes_taken     <= bytes_taken_next;
      final_status    <= final_status_next;
      if (pop) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_item.body_byte  <= body_valid ? pop_item.data_byte : 8'd0;
      res_item.body_valid <= body_valid;
      res_item.status     <= final_status_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    line_next            = line;
    pending_cr_next      = pending_cr;
    bytes_taken_next     = bytes_taken;
    final_status_next    = final_status;
    body_valid           = 1'b0;
    // A CR held back from the previous byte counts as a plain line character.
    line_cr = pending_cr ? line_char(line, 1'b0, 1'b0, 4'd0) : line;
    if (pop && final_status == ST_RUN) begin
      if (!chunked_mode) begin
        if (bytes_taken < limit) begin
          body_valid       = 1'b1;
          bytes_taken_next = taken_inc;
          if (taken_inc == limit) begin
            final_status_next = ST_DONE;
          end
        end else begin
          final_status_next = ST_DONE;
        end
      end else begin
        case (phase)
          PH_SIZE: begin
            if (pending_cr && pop_item.is_lf) begin
              if (line.accum == '0) begin
                final_status_next = (line.shape == SH_ZERO) ? ST_DONE : ST_BAD_ZERO;
              end else begin
                chunk_remaining_next = line.accum;
                phase_next           = PH_DATA;
              end
              line_next       = '{accum: '0, stopped: 1'b0, shape: SH_EMPTY};
              pending_cr_next = 1'b0;
            end else if (pop_item.is_cr) begin
              line_next       = line_cr;
              pending_cr_next = 1'b1;
            end else begin
              line_next       = line_char(line_cr, pop_item.is_zero, pop_item.is_hex,
                                          pop_item.hex);
              pending_cr_next = 1'b0;
            end
          end
          PH_DATA: begin
            body_valid = 1'b1;
            if (chunk_remaining != '0) begin
              chunk_remaining_next = remaining_dec;
            end
            if (chunk_remaining_next == '0) begin
              phase_next = PH_CR;
            end
          end
          PH_CR: begin
            if (pop_item.is_cr) begin
              phase_next = PH_LF;
            end else begin
              final_status_next = ST_NO_CRLF;
            end
          end
          default: begin
            if (pop_item.is_lf) begin
              phase_next = PH_SIZE;
            end else begin
              final_status_next = ST_NO_CRLF;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== design/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Extracts an HTTP request body by content length or chunked decoding.
// ----------------------------------------------------------------------------
// Path: each byte's result passes through the queue and then the registered
// result stage before it is offered.
// Throughput: one byte per cycle while the result side takes each result.
// Reset: synchronous; clears the decoder state, queue and configuration
// registers at once, with no clearing pass.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hcbd_chan_if.sink   stream,
  hcbd_chan_if.source result,
  hcbd_chan_if.sink   cfg
);

  logic        chunked_mode;
  logic [31:0] content_length;
  logic        push_valid;
  logic        push_ready;
  cls_t        push_item;
  logic        pop_valid;
  logic        pop_ready;
  cls_t        pop_item;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode   <= 1'b0;
      content_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        CFG_CHUNKED_MODE:   chunked_mode   <= cfg.payload.value[0];
        CFG_CONTENT_LENGTH: content_length <= cfg.payload.value;
        default: ;
      endcase
    end
  end

  hcbd_front u_front (
    .stream     (stream),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  hcbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  hcbd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .chunked_mode   (chunked_mode),
    .content_length (content_length),
    .pop_valid      (pop_valid),
    .pop_item       (pop_item),
    .pop_ready      (pop_ready),
    .result         (result)
  );

endmodule

// ===== tb/http_chunked_body_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Drives a raw request body stream into the decoder and checks every result
// against a cycle-free model of the decoder. The stream is built mostly from
// well-formed chunks with random sizes, extensions and payloads, with length
// mode stretches cut in. Each run finishes with one randomly chosen
// terminating case, because completion and errors hold until reset.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int CALM_FIRST     = 500;
  localparam int CALM_LAST      = 1100;

  logic clk;
  logic rst;

  hcbd_chan_if #(.payload_t(in_item_t))  stream_if ();
  hcbd_chan_if #(.payload_t(out_item_t)) result_if ();
  hcbd_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  http_chunked_body_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  // Bytes waiting to be sent and decoder results still to arrive.
  logic [7:0]  tx_bytes[$];
  out_item_t   expected_out[$];

  int unsigned fail_count  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cyc         = 0;
  int unsigned quiet_count = 0;
  logic        stream_took = 1'b0;

  // Decoder model state and its copy of the configuration registers.
  phase_t      dec_phase    = PH_SIZE;
  logic [31:0] chunk_left   = '0;
  logic [31:0] size_acc     = '0;
  logic        digits_done  = 1'b0;
  shape_t      line_kind    = SH_EMPTY;
  logic        cr_held      = 1'b0;
  logic [31:0] len_count    = '0;
  status_t     body_status  = ST_RUN;
  logic        mode_chunked = 1'b0;
  logic [31:0] body_len     = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void take_line_char(input logic [7:0] c);
    int              d;
    longint unsigned dd;
    d = hex_val(c);
    if (line_kind == SH_EMPTY && c == CHAR_ZERO) line_kind = SH_ZERO;
    else line_kind = SH_OTHER;
    if (digits_done || d < 0) begin
      digits_done = 1'b1;
    end else begin
      dd = longint'(d);
      // The size saturates rather than wrapping.
      if (longint'(size_acc) > (64'hFFFF_FFFF - dd) / 16) size_acc = '1;
      else size_acc = size_acc * 16 + d;
    end
  endfunction

  function automatic out_item_t decode_byte(input logic [7:0] c);
    out_item_t r;
    logic      pass;
    pass = 1'b0;
    if (body_status == ST_RUN) begin
      if (!mode_chunked) begin
        if (len_count < body_len) begin
          pass = 1'b1;
          len_count = len_count + 1;
        end
        if (len_count >= body_len) body_status = ST_DONE;
      end else begin
        case (dec_phase)
          PH_SIZE: begin
            if (cr_held && c == CHAR_LF) begin
              if (size_acc == 0) begin
                body_status = (line_kind == SH_ZERO) ? ST_DONE : ST_BAD_ZERO;
              end else begin
                chunk_left = size_acc;
                dec_phase  = PH_DATA;
              end
              size_acc    = '0;
              digits_done = 1'b0;
              line_kind   = SH_EMPTY;
              cr_held     = 1'b0;
            end else begin
              // A CR not followed by LF is an ordinary character of the line.
              if (cr_held) begin
                take_line_char(CHAR_CR);
                cr_held = 1'b0;
              end
              if (c == CHAR_CR) cr_held = 1'b1;
              else take_line_char(c);
            end
          end
          PH_DATA: begin
            pass = 1'b1;
            if (chunk_left > 0) chunk_left = chunk_left - 1;
            if (chunk_left == 0) dec_phase = PH_CR;
          end
          PH_CR: begin
            if (c == CHAR_CR) dec_phase = PH_LF;
            else body_status = ST_NO_CRLF;
          end
          default: begin
            if (c == CHAR_LF) dec_phase = PH_SIZE;
            else body_status = ST_NO_CRLF;
          end
        endcase
      end
    end
    r.body_byte  = pass ? c : 8'h00;
    r.body_valid = pass;
    r.status     = body_status;
    return r;
  endfunction

  function automatic bit skip_cycle();
    if (cyc >= CALM_FIRST && cyc < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < 19;
  endfunction

  function automatic void log_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return CHAR_ZERO + nib;
    return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    tx_bytes = {tx_bytes, b};
    bytes_sent++;
  endfunction

  // One whole chunk: size line, optional extension, payload and closing CR LF.
  task automatic build_chunk(ref logic [7:0] q[$], input int unsigned size);
    bit         started;
    logic [7:0] b;
    started = 1'b0;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) q = {q, CHAR_ZERO};
    for (int i = 7; i >= 0; i--) begin
      if (size[4*i +: 4] != 0 || started || i == 0) begin
        started = 1'b1;
        b = hex_char(size[4*i +: 4]);
        q = {q, b};
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      // The extension opens with a non-hex character so the size is untouched.
      case ($urandom_range(0, 2))
        0:       b = ";";
        1:       b = " ";
        default: b = CHAR_CR;
      endcase
      q = {q, b};
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (q[$] == CHAR_CR && b == CHAR_LF) b = ";";
        q = {q, b};
      end
    end
    q = {q, CHAR_CR};
    q = {q, CHAR_LF};
    repeat (size) begin
      b = 8'($urandom_range(0, 255));
      q = {q, b};
    end
    q = {q, CHAR_CR};
    q = {q, CHAR_LF};
  endtask

  task automatic wait_all_results();
    while (tx_bytes.size() != 0 || expected_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_CHUNKED_MODE) mode_chunked = val[0];
    else body_len = val;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_mode(input logic chunked);
    logic [31:0] val;
    val    = $urandom;
    val[0] = chunked;
    write_reg(CFG_CHUNKED_MODE, val);
  endtask

  // A stretch of length mode cut into the chunked stream; the state carries over.
  task automatic length_interlude();
    int unsigned n;
    logic [31:0] lim;
    n = $urandom_range(1, 20);
    wait_all_results();
    set_mode(1'b0);
    lim = $urandom;
    if (lim <= len_count + n || $urandom_range(0, 3) == 0) lim = '1;
    write_reg(CFG_CONTENT_LENGTH, lim);
    repeat (n) queue_byte(8'($urandom_range(0, 255)));
    wait_all_results();
    set_mode(1'b1);
  endtask

  // Sender: holds valid until the transfer, then takes the next byte or idles.
  always @(negedge clk) begin
    if (rst) begin
      stream_if.valid <= 1'b0;
    end else if (!stream_if.valid || stream_took) begin
      if (tx_bytes.size() != 0 && !skip_cycle()) begin
        stream_if.valid   <= 1'b1;
        stream_if.payload <= tx_bytes[0];
      end else begin
        stream_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    stream_took <= !rst && stream_if.valid && stream_if.ready;
    if (!rst && stream_if.valid && stream_if.ready) begin
      expected_out = {expected_out, decode_byte(stream_if.payload.data_byte)};
      void'(tx_bytes.pop_front());
    end
  end

  always @(negedge clk) begin
    result_if.ready <= !rst && !skip_cycle();
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (expected_out.size() == 0) begin
        log_fail($sformatf("result with nothing expected: byte %02h valid %0b status %0d",
                           got.body_byte, got.body_valid, got.status));
      end else begin
        want = expected_out.pop_front();
        if (got.body_byte !== want.body_byte)
          log_fail($sformatf("body_byte: expected %02h, got %02h",
                             want.body_byte, got.body_byte));
        if (got.body_valid !== want.body_valid)
          log_fail($sformatf("body_valid: expected %0b, got %0b",
                             want.body_valid, got.body_valid));
        if (got.status !== want.status)
          log_fail($sformatf("status: expected %0d, got %0d", want.status, got.status));
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst) begin
      cyc <= cyc + 1;
      if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_count <= 0;
      end else if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  part[$];
    int unsigned sz;
    int unsigned cut;
    int unsigned k;
    rst               = 1'b1;
    stream_if.valid   = 1'b0;
    stream_if.payload = '0;
    result_if.ready   = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.payload    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Length mode with the largest length: every byte passes.
    write_reg(CFG_CHUNKED_MODE, 32'h0000_0000);
    write_reg(CFG_CONTENT_LENGTH, 32'hFFFF_FFFF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
    queue_byte(CHAR_ZERO);
    wait_all_results();

    // Chunked mode; the length register has no effect here.
    write_reg(CFG_CHUNKED_MODE, 32'hFFFF_FFFF);
    write_reg(CFG_CONTENT_LENGTH, 32'h0000_0000);
    queue_byte("1");
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
    queue_byte(8'h00);
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
    // A lone CR after the digits counts as text and leaves the size at two.
    queue_byte("2");
    queue_byte(CHAR_CR);
    queue_byte("z");
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(CHAR_CR);
    queue_byte(CHAR_LF);

    while (bytes_sent < 1400) begin
      sz = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      part.delete();
      build_chunk(part, sz);
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(0, part.size());
        for (int i = 0; i < cut; i++) queue_byte(part[i]);
        length_interlude();
        for (int i = cut; i < part.size(); i++) queue_byte(part[i]);
      end else begin
        foreach (part[i]) queue_byte(part[i]);
      end
      if ($urandom_range(0, 19) == 0) wait_all_results();
    end

    // One terminating case per run, then bytes that must be dropped.
    case ($urandom_range(0, 5))
      0: begin
        queue_byte(CHAR_ZERO);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
      end
      1: begin
        case ($urandom_range(0, 4))
          0: ;
          1: begin
            queue_byte(CHAR_ZERO);
            queue_byte(CHAR_ZERO);
          end
          2: begin
            queue_byte(CHAR_ZERO);
            queue_byte("x");
          end
          3: begin
            queue_byte(CHAR_ZERO);
            queue_byte(CHAR_CR);
            queue_byte("q");
          end
          default: begin
            queue_byte("g");
            queue_byte("5");
          end
        endcase
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
      end
      2: begin
        part.delete();
        build_chunk(part, $urandom_range(1, 8));
        if ($urandom_range(0, 1)) begin
          part[part.size() - 2] = 8'($urandom_range(0, 255));
          if (part[part.size() - 2] == CHAR_CR) part[part.size() - 2] = "x";
        end else begin
          part[part.size() - 1] = 8'($urandom_range(0, 255));
          if (part[part.size() - 1] == CHAR_LF) part[part.size() - 1] = "x";
        end
        foreach (part[i]) queue_byte(part[i]);
      end
      3, 4: begin
        k = $urandom_range(1, 4);
        wait_all_results();
        set_mode(1'b0);
        write_reg(CFG_CONTENT_LENGTH, (cyc % 2 == 0) ? len_count + k : 32'h0000_0000);
      end
      default: begin
        // Too many digits: the size saturates and the chunk never ends.
        repeat ($urandom_range(9, 12)) queue_byte(hex_char(4'hF));
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
      end
    endcase
    repeat (20) queue_byte(8'($urandom_range(0, 255)));

    wait_all_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== http_chunked_body_decoder.f =====
design/hcbd_pkg.sv
design/hcbd_chan_if.sv
design/hcbd_front.sv
design/hcbd_queue.sv
design/hcbd_back.sv
design/http_chunked_body_decoder.sv
tb/http_chunked_body_decoder_tb.sv
